>>> rtl/gbba_pkg.sv
package gbba_pkg;

  // Opcodes of an input transaction.
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_MARK  = 3'd1;
  localparam logic [2:0] OP_SCAN  = 3'd2;
  localparam logic [2:0] OP_PLAN  = 3'd3;
  localparam logic [2:0] OP_ALLOC = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Scan modes.
  localparam logic [1:0] SCAN_NORMAL = 2'd0;
  localparam logic [1:0] SCAN_FIXED  = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BPG   = 2'd0;
  localparam logic [1:0] CFG_IPG   = 2'd1;
  localparam logic [1:0] CFG_GCNT  = 2'd2;
  localparam logic [1:0] CFG_TOTAL = 2'd3;

  // The fixed-block bitmap is stored as rows of 32 bits.
  localparam int ROW_BITS  = 32;
  localparam int ROW_SHIFT = 5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  group_index;
    logic [13:0] free_count;
    logic [15:0] block_number;
    logic [15:0] inode_number;
    logic [1:0]  scan_mode;
  } gbba_in_t;

  typedef struct packed {
    logic [15:0] chosen_block;
    logic [1:0]  status;
  } gbba_out_t;

  // One entry of the group table.
  typedef struct packed {
    logic [15:0] free;
    logic [15:0] native;
    logic [15:0] away;
    logic [15:0] back;
    logic [16:0] next_fill;
    logic [15:0] last;
  } gbba_rec_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    inc16 = (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
  endfunction

endpackage

>>> rtl/gbba_div.sv
module gbba_div import gbba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [13:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  // Restoring division, one quotient bit per cycle.
  logic [13:0] rem;
  logic [15:0] quo;
  logic [13:0] dvs;
  logic [4:0]  cnt;
  logic [14:0] trial;

  assign trial    = {rem, quo[15]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 5'd1);
      if (start) begin
        cnt <= 5'd16;
      end else if (cnt != 5'd0) begin
        cnt <= cnt - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != 5'd0) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 14'(trial - {1'b0, dvs});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial[13:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/gbba_gtab.sv
module gbba_gtab import gbba_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  gbba_rec_t     wdata,
  input  logic [AW-1:0] raddr,
  output gbba_rec_t     rdata
);

  gbba_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gbba_fixmap.sv
module gbba_fixmap import gbba_pkg::*; #(
  parameter int ROWS = 2048,
  parameter int AW   = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [ROW_BITS-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [ROW_BITS-1:0] rdata
);

  logic [ROW_BITS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/group_balanced_block_allocator_top.sv
// Group-balanced block allocator.
// Input transactions arrive on in_valid/in_stall/in_data; each one gives exactly one
// result transaction on out_valid/out_stall/out_data. Configuration registers must be
// written through cfg_we/cfg_index/cfg_data while the block is idle; the block itself
// does not enforce this. The block works on one transaction at a time. A load is one
// read-modify-write pass on the group table, a mark one on the bitmap, a scan two
// divisions on the shared divider plus up to two read-modify-write passes on the group
// table, and a plan visits each group in use. An allocation served by its own group
// needs the inode division; each fixed block skipped in a window adds a bitmap check,
// and the fallback search reads every group it passes and the window of each group
// with a free estimate. Its cost is set by the serial divider and by the
// one-read-per-cycle group table and bitmap.
// After reset a clearing pass writes zero to every group table entry and every
// bitmap row, and in_stall stays high until it ends. Configuration registers return
// to their reset values at once.
// A finished result sits in the output register; when the receiver stalls it holds
// there, and the next transaction is not finished until that register is free.
module group_balanced_block_allocator_top import gbba_pkg::*; #(
  parameter int MAX_GROUPS = 64,
  parameter int MAX_BLOCKS = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  gbba_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output gbba_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // Group index width, search counter width (one extra bit so it can pass the end).
  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW    = GW + 1;
  localparam int PW    = CW + 14;
  localparam int ROWS  = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int FAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CLR_N = (ROWS > MAX_GROUPS) ? ROWS : MAX_GROUPS;
  localparam int CLW   = $clog2(CLR_N);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_DSTART = 16'h0004,
    S_DWAIT  = 16'h0008,
    S_URD    = 16'h0010,
    S_UMOD   = 16'h0020,
    S_MRD    = 16'h0040,
    S_MMOD   = 16'h0080,
    S_PRD    = 16'h0100,
    S_PWR    = 16'h0200,
    S_GRD    = 16'h0400,
    S_GDAT   = 16'h0800,
    S_ADV    = 16'h1000,
    S_FCHK   = 16'h2000,
    S_WB     = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  // Which counter a read-modify-write pass on the group table updates.
  typedef enum logic [1:0] {
    U_LOAD   = 2'd0,
    U_NATIVE = 2'd1,
    U_AWAY   = 2'd2,
    U_BACK   = 2'd3
  } upd_t;

  state_t     state;
  logic [CLW-1:0] clr;

  // Configuration registers.
  logic [13:0] bpg;
  logic [13:0] ipg;
  logic [6:0]  gcnt;
  logic [15:0] tblk;

  // Transaction under work and its bookkeeping.
  gbba_in_t    item;
  logic        div_sel;
  logic [GW-1:0] ig;
  logic        ig_ok;
  logic [GW-1:0] uaddr;
  upd_t        ufield;
  logic        second;
  logic [CW-1:0] cur;
  logic        searching;
  logic        up;
  logic        found;
  gbba_rec_t   rec;
  logic [PW-1:0] prod;
  logic [15:0] res_block;
  logic [1:0]  res_status;

  // Memory ports.
  logic          gt_we;
  logic [GW-1:0] gt_waddr;
  logic [GW-1:0] gt_raddr;
  gbba_rec_t     gt_wdata;
  gbba_rec_t     gt_rdata;
  logic          fx_we;
  logic [FAW-1:0] fx_waddr;
  logic [FAW-1:0] fx_raddr;
  logic [ROW_BITS-1:0] fx_wdata;
  logic [ROW_BITS-1:0] fx_rdata;

  // Divider.
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] div_x;
  logic [13:0] div_d;
  logic        div_ok;

  // Derived values.
  logic [15:0] ngrp;
  logic [31:0] nf_ext;
  logic [31:0] blk_ext;
  logic        win_out;
  gbba_rec_t   umod;
  gbba_rec_t   pmod;
  gbba_rec_t   taken;
  logic [CW-1:0] nxt_cur;
  logic        nxt_up;
  logic        nxt_end;
  logic [16:0] fsum;
  logic [15:0] fsat;
  logic [31:0] nx32;
  logic [31:0] ls32;
  logic        plan_last;

  // Groups in use are the group count clamped to the table depth.
  assign ngrp    = (32'(gcnt) > MAX_GROUPS) ? 16'(MAX_GROUPS) : {9'd0, gcnt};
  assign nf_ext  = 32'(rec.next_fill);
  assign blk_ext = 32'(item.block_number);
  assign win_out = rec.next_fill > {1'b0, rec.last};

  assign in_stall = (state != S_IDLE);

  gbba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_x - 16'd1),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  gbba_gtab #(
    .DEPTH (MAX_GROUPS),
    .AW    (GW)
  ) u_gtab (
    .clk   (clk),
    .we    (gt_we),
    .waddr (gt_waddr),
    .wdata (gt_wdata),
    .raddr (gt_raddr),
    .rdata (gt_rdata)
  );

  gbba_fixmap #(
    .ROWS (ROWS),
    .AW   (FAW)
  ) u_fixmap (
    .clk   (clk),
    .we    (fx_we),
    .waddr (fx_waddr),
    .wdata (fx_wdata),
    .raddr (fx_raddr),
    .rdata (fx_rdata)
  );

  // The shared divider finds the group of an inode first and, for a scan, then of a block.
  assign div_start = (state == S_DSTART);
  assign div_x     = div_sel ? item.block_number : item.inode_number;
  assign div_d     = div_sel ? bpg : ipg;
  assign div_ok    = (div_x != 16'd0) && (div_d != 14'd0) && (div_q < ngrp);

  // Counter update for load and scan transactions.
  always_comb begin
    umod = gt_rdata;
    case (ufield)
      U_LOAD:   umod.free   = {2'b00, item.free_count};
      U_NATIVE: umod.native = inc16(gt_rdata.native);
      U_AWAY:   umod.away   = inc16(gt_rdata.away);
      U_BACK:   umod.back   = inc16(gt_rdata.back);
      default:  umod = gt_rdata;
    endcase
  end

  // Plan: free estimate and the fill window of group cur.
  always_comb begin
    fsum      = {1'b0, gt_rdata.free} + {1'b0, gt_rdata.away};
    fsat      = fsum[16] ? 16'hFFFF : fsum[15:0];
    nx32      = 32'(prod) + 32'd1;
    ls32      = 32'(prod) + 32'(bpg);
    plan_last = (16'(cur) == ngrp - 16'd1);
    pmod           = gt_rdata;
    pmod.free      = (fsat > gt_rdata.back) ? fsat - gt_rdata.back : 16'd0;
    pmod.native    = 16'd0;
    pmod.away      = 16'd0;
    pmod.next_fill = (nx32 > 32'h1FFFF) ? 17'h1FFFF : nx32[16:0];
    if (plan_last) begin
      pmod.last = tblk - 16'd1;
    end else begin
      pmod.last = (ls32 > 32'hFFFF) ? 16'hFFFF : ls32[15:0];
    end
  end

  // The entry after a block is taken from the head of its window.
  always_comb begin
    taken           = rec;
    taken.next_fill = rec.next_fill + 17'd1;
    if (searching) begin
      taken.free = rec.free - 16'd1;
      taken.away = inc16(rec.away);
    end else begin
      taken.native = inc16(rec.native);
    end
  end

  // Fallback order: own group, then lower groups downward, then higher groups upward.
  always_comb begin
    nxt_cur = cur + CW'(1);
    nxt_up  = 1'b1;
    if (!searching || !up) begin
      if (cur == '0) begin
        nxt_cur = (searching ? CW'(ig) : cur) + CW'(1);
        nxt_up  = 1'b1;
      end else begin
        nxt_cur = cur - CW'(1);
        nxt_up  = 1'b0;
      end
    end
    nxt_end = nxt_up && (16'(nxt_cur) >= ngrp);
  end

  // Group table port selection.
  always_comb begin
    gt_we    = 1'b0;
    gt_waddr = cur[GW-1:0];
    gt_wdata = rec;
    gt_raddr = cur[GW-1:0];
    unique case (state)
      S_CLEAR: begin
        gt_we    = (32'(clr) < MAX_GROUPS);
        gt_waddr = clr[GW-1:0];
        gt_wdata = '0;
      end
      S_URD: begin
        gt_raddr = uaddr;
      end
      S_UMOD: begin
        gt_we    = 1'b1;
        gt_waddr = uaddr;
        gt_wdata = umod;
      end
      S_PWR: begin
        gt_we    = 1'b1;
        gt_wdata = pmod;
      end
      S_WB: begin
        gt_we = 1'b1;
      end
      default: begin
        gt_we = 1'b0;
      end
    endcase
  end

  // Bitmap port selection.
  always_comb begin
    fx_we    = 1'b0;
    fx_waddr = blk_ext[FAW+ROW_SHIFT-1:ROW_SHIFT];
    fx_wdata = fx_rdata | (ROW_BITS'(1) << item.block_number[ROW_SHIFT-1:0]);
    fx_raddr = blk_ext[FAW+ROW_SHIFT-1:ROW_SHIFT];
    unique case (state)
      S_CLEAR: begin
        fx_we    = (32'(clr) < ROWS);
        fx_waddr = clr[FAW-1:0];
        fx_wdata = '0;
      end
      S_MMOD: begin
        fx_we = 1'b1;
      end
      S_ADV: begin
        fx_raddr = nf_ext[FAW+ROW_SHIFT-1:ROW_SHIFT];
      end
      default: begin
        fx_we = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bpg  <= 14'd8192;
      ipg  <= 14'd2048;
      gcnt <= 7'd8;
      tblk <= 16'd65535;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPG:   bpg  <= cfg_data[13:0];
        CFG_IPG:   ipg  <= cfg_data[13:0];
        CFG_GCNT:  gcnt <= cfg_data[6:0];
        CFG_TOTAL: tblk <= cfg_data;
        default:   tblk <= tblk;
      endcase
    end
  end

  // Output register: a result is loaded when the register is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_data.chosen_block <= res_block;
      out_data.status       <= res_status;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      searching <= 1'b0;
      up        <= 1'b0;
      found     <= 1'b0;
      second    <= 1'b0;
      div_sel   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (32'(clr) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            res_block  <= 16'd0;
            res_status <= ST_OK;
            found      <= 1'b0;
            searching  <= 1'b0;
            up         <= 1'b0;
            second     <= 1'b0;
            div_sel    <= 1'b0;
            case (in_data.opcode)
              OP_LOAD: begin
                if ({10'd0, in_data.group_index} >= ngrp) begin
                  res_status <= ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  uaddr  <= GW'(in_data.group_index);
                  ufield <= U_LOAD;
                  state  <= S_URD;
                end
              end
              OP_MARK: begin
                state <= (32'(in_data.block_number) < MAX_BLOCKS) ? S_MRD : S_OUT;
              end
              OP_SCAN, OP_ALLOC: begin
                state <= S_DSTART;
              end
              OP_PLAN: begin
                cur   <= '0;
                state <= S_PRD;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end

        S_DSTART: begin
          state <= S_DWAIT;
        end

        S_DWAIT: begin
          if (div_done) begin
            if (!div_sel) begin
              ig    <= GW'(div_q);
              ig_ok <= div_ok;
              if (item.opcode == OP_ALLOC) begin
                if (!div_ok) begin
                  res_status <= ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  cur   <= CW'(div_q);
                  state <= S_GRD;
                end
              end else begin
                div_sel <= 1'b1;
                state   <= S_DSTART;
              end
            end else if (!(ig_ok && div_ok)) begin
              res_status <= ST_RANGE;
              state      <= S_OUT;
            end else if (item.scan_mode == SCAN_FIXED) begin
              uaddr  <= GW'(div_q);
              ufield <= U_NATIVE;
              state  <= S_URD;
            end else if (item.scan_mode == SCAN_NORMAL) begin
              uaddr <= GW'(div_q);
              if (ig == GW'(div_q)) begin
                ufield <= U_NATIVE;
              end else begin
                // Away on the block's group, then back on the inode's group.
                ufield <= U_AWAY;
                second <= 1'b1;
              end
              state <= S_URD;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_URD: begin
          state <= S_UMOD;
        end

        S_UMOD: begin
          if (second) begin
            second <= 1'b0;
            uaddr  <= ig;
            ufield <= U_BACK;
            state  <= S_URD;
          end else begin
            state <= S_OUT;
          end
        end

        S_MRD: begin
          state <= S_MMOD;
        end

        S_MMOD: begin
          state <= S_OUT;
        end

        S_PRD: begin
          if (16'(cur) >= ngrp) begin
            state <= S_OUT;
          end else begin
            prod  <= PW'(cur) * PW'(bpg);
            state <= S_PWR;
          end
        end

        S_PWR: begin
          cur   <= cur + CW'(1);
          state <= S_PRD;
        end

        S_GRD: begin
          state <= S_GDAT;
        end

        S_GDAT: begin
          rec <= gt_rdata;
          if (searching && gt_rdata.free == 16'd0) begin
            // In the fallback search a group with no free estimate is passed over unchanged.
            searching <= 1'b1;
            cur       <= nxt_cur;
            up        <= nxt_up;
            if (nxt_end) begin
              res_status <= ST_NOFREE;
              state      <= S_OUT;
            end else begin
              state <= S_GRD;
            end
          end else begin
            state <= S_ADV;
          end
        end

        S_ADV: begin
          if (win_out) begin
            state <= S_WB;
          end else if (nf_ext >= MAX_BLOCKS) begin
            res_block <= rec.next_fill[15:0];
            rec       <= taken;
            found     <= 1'b1;
            state     <= S_WB;
          end else begin
            state <= S_FCHK;
          end
        end

        S_FCHK: begin
          if (fx_rdata[rec.next_fill[ROW_SHIFT-1:0]]) begin
            rec.next_fill <= rec.next_fill + 17'd1;
            state         <= S_ADV;
          end else begin
            res_block <= rec.next_fill[15:0];
            rec       <= taken;
            found     <= 1'b1;
            state     <= S_WB;
          end
        end

        S_WB: begin
          // The window is written back even when it ran out.
          if (found) begin
            state <= S_OUT;
          end else begin
            searching <= 1'b1;
            cur       <= nxt_cur;
            up        <= nxt_up;
            if (nxt_end) begin
              res_status <= ST_NOFREE;
              state      <= S_OUT;
            end else begin
              state <= S_GRD;
            end
          end
        end

        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
